// ----- rtl/vap_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vap_pkg
// shared types, command codes and address helpers for the video memory port
// ----------------------------------------------------------------------------
package vap_pkg;

   localparam int MEM_WORDS = 32768;
   localparam int MEM_AW    = $clog2(MEM_WORDS);

   localparam int CMD_W  = 3;
   localparam int BYTE_W = 8;
   localparam int WORD_W = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADDR_LO  = 3'd0,
      CMD_ADDR_HI  = 3'd1,
      CMD_WRITE_LO = 3'd2,
      CMD_WRITE_HI = 3'd3,
      CMD_READ_LO  = 3'd4,
      CMD_READ_HI  = 3'd5
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INCREMENT_SELECT = 2'd0,
      CSR_REMAP_MODE       = 2'd1,
      CSR_STEP_AFTER_HIGH  = 2'd2
   } csr_index_type;

   typedef enum logic {
      ST_IDLE,
      ST_FETCH
   } state_type;

   typedef struct packed {
      logic              read_en;
      logic              write_lo;
      logic              write_hi;
      logic [MEM_AW-1:0] index;
      logic [BYTE_W-1:0] data;
   } mem_req_type;

   function automatic logic [WORD_W-1:0] addr_step(input logic [1:0] sel);
      logic [WORD_W-1:0] step;
      case (sel)
         2'd0:    step = 16'd1;
         2'd1:    step = 16'd32;
         2'd2:    step = 16'd128;
         default: step = 16'd128;
      endcase
      return step;
   endfunction

   function automatic logic [WORD_W-1:0] addr_remap(input logic [WORD_W-1:0] a,
                                                    input logic [1:0] mode);
      logic [WORD_W-1:0] r;
      case (mode)
         2'd1:    r = {a[15:8], a[4:0], a[7:5]};
         2'd2:    r = {a[15:9], a[5:0], a[8:6]};
         2'd3:    r = {a[15:10], a[6:0], a[9:7]};
         default: r = a;
      endcase
      return r;
   endfunction

endpackage

// ----- rtl/vram_access_port.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vram_access_port
// byte-wide bus access port to a word video memory with read prefetch latch
// ----------------------------------------------------------------------------
// the result strobe is registered and comes in the cycle after the accepting edge
// one access per cycle while not busy; address loads and stepping reads
//   refetch the latch and raise busy, so no new access is taken meanwhile
// the refetch waits for the registered read of the single memory port
// reset clears address, latch and config; memory content is undefined
// results cannot be stalled by the receiver
module vram_access_port (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [vap_pkg::CMD_W-1:0]        req_cmd,
   input  logic [vap_pkg::BYTE_W-1:0]       req_bus_byte,
   input  logic                             req_access_blocked,
   output logic                             rsp_strobe,
   output logic [vap_pkg::BYTE_W-1:0]       rsp_read_byte,
   input  logic                             csr_write_enable,
   input  logic [vap_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [vap_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import vap_pkg::*;

   state_type         state_ff, state_in;
   logic [1:0]        increment_select_ff;
   logic [1:0]        remap_mode_ff;
   logic              step_after_high_ff;
   logic [WORD_W-1:0] prefetch_ff, prefetch_in;
   logic              blocked_ff, blocked_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   logic [BYTE_W-1:0] rsp_read_byte_ff, rsp_read_byte_in;

   logic              accept;
   logic              advance;
   logic              fetch;
   cmd_type           cmd;
   logic [MEM_AW-1:0] mem_index;
   logic [WORD_W-1:0] rd_data;
   mem_req_type       mem_req;

   assign cmd    = cmd_type'(req_cmd);
   assign accept = start && (state_ff == ST_IDLE);

   vap_addr u_addr (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .cmd              (cmd),
      .bus_byte         (req_bus_byte),
      .advance          (advance),
      .increment_select (increment_select_ff),
      .remap_mode       (remap_mode_ff),
      .mem_index        (mem_index)
   );

   vap_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   always_comb begin
      advance = 1'b0;
      fetch   = 1'b0;
      rsp_read_byte_in = '0;
      case (cmd)
         CMD_ADDR_LO, CMD_ADDR_HI: begin
            fetch = 1'b1;
         end
         CMD_WRITE_LO: begin
            advance = !step_after_high_ff;
         end
         CMD_WRITE_HI: begin
            advance = step_after_high_ff;
         end
         CMD_READ_LO: begin
            advance = !step_after_high_ff;
            fetch   = !step_after_high_ff;
            rsp_read_byte_in = prefetch_ff[7:0];
         end
         CMD_READ_HI: begin
            advance = step_after_high_ff;
            fetch   = step_after_high_ff;
            rsp_read_byte_in = prefetch_ff[15:8];
         end
         default: begin
         end
      endcase

      mem_req.index    = mem_index;
      mem_req.data     = req_bus_byte;
      mem_req.read_en  = accept && fetch && !req_access_blocked;
      mem_req.write_lo = accept && (cmd == CMD_WRITE_LO) && !req_access_blocked;
      mem_req.write_hi = accept && (cmd == CMD_WRITE_HI) && !req_access_blocked;
   end

   always_comb begin
      state_in      = state_ff;
      prefetch_in   = prefetch_ff;
      blocked_in    = blocked_ff;
      rsp_strobe_in = accept;
      case (state_ff)
         ST_IDLE: begin
            if (accept && fetch) begin
               state_in   = ST_FETCH;
               blocked_in = req_access_blocked;
            end
         end
         ST_FETCH: begin
            prefetch_in = blocked_ff ? '0 : rd_data;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff            <= ST_IDLE;
         increment_select_ff <= '0;
         remap_mode_ff       <= '0;
         step_after_high_ff  <= 1'b0;
         prefetch_ff         <= '0;
         rsp_strobe_ff       <= 1'b0;
      end else begin
         state_ff      <= state_in;
         prefetch_ff   <= prefetch_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_write_enable) begin
            case (csr_index_type'(csr_index))
               CSR_INCREMENT_SELECT: increment_select_ff <= csr_write_data[1:0];
               CSR_REMAP_MODE:       remap_mode_ff       <= csr_write_data[1:0];
               CSR_STEP_AFTER_HIGH:  step_after_high_ff  <= csr_write_data[0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      blocked_ff       <= blocked_in;
      rsp_read_byte_ff <= rsp_read_byte_in;
   end

   assign busy          = (state_ff == ST_FETCH);
   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_read_byte = rsp_read_byte_ff;

endmodule

// ----- rtl/vap_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vap_mem
// word memory with byte write lanes and a registered read port
// ----------------------------------------------------------------------------
module vap_mem (
   input  logic                              clock,
   input  vap_pkg::mem_req_type              mem_req,
   output logic [vap_pkg::WORD_W-1:0]        rd_data
);
   import vap_pkg::*;

   logic [1:0][BYTE_W-1:0] mem [MEM_WORDS];
   logic [WORD_W-1:0]      rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.write_lo) begin
         mem[mem_req.index][0] <= mem_req.data;
      end
      if (mem_req.write_hi) begin
         mem[mem_req.index][1] <= mem_req.data;
      end
      if (mem_req.read_en) begin
         rd_data_ff <= mem[mem_req.index];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/vap_addr.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vap_addr
// word address register with byte loads, stepping and index remapping
// ----------------------------------------------------------------------------
module vap_addr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  vap_pkg::cmd_type              cmd,
   input  logic [vap_pkg::BYTE_W-1:0]    bus_byte,
   input  logic                          advance,
   input  logic [1:0]                    increment_select,
   input  logic [1:0]                    remap_mode,
   output logic [vap_pkg::MEM_AW-1:0]    mem_index
);
   import vap_pkg::*;

   logic [WORD_W-1:0] word_address_ff;
   logic [WORD_W-1:0] word_address_in;
   logic [WORD_W-1:0] eff_address;
   logic [WORD_W-1:0] remapped;

   always_comb begin
      case (cmd)
         CMD_ADDR_LO: eff_address = {word_address_ff[15:8], bus_byte};
         CMD_ADDR_HI: eff_address = {bus_byte, word_address_ff[7:0]};
         default:     eff_address = word_address_ff;
      endcase
      remapped = addr_remap(eff_address, remap_mode);
      mem_index = remapped[MEM_AW-1:0];

      word_address_in = word_address_ff;
      if (accept) begin
         if (advance) begin
            word_address_in = word_address_ff + addr_step(increment_select);
         end else begin
            word_address_in = eff_address;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_address_ff <= '0;
      end else begin
         word_address_ff <= word_address_in;
      end
   end

endmodule

// ----- rtl/vap_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vap_checker
// port-level checks of transfer timing and result bytes for the video memory port
// ----------------------------------------------------------------------------
module vap_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic                             busy,
   input  logic [vap_pkg::CMD_W-1:0]        req_cmd,
   input  logic                             rsp_strobe,
   input  logic [vap_pkg::BYTE_W-1:0]       rsp_read_byte
);
   import vap_pkg::*;

   // every accepted transfer yields a result in the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_strobe)
      else $error("missing result after accepted transfer");

   // no result without an accepted transfer
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |=> !rsp_strobe)
      else $error("result without accepted transfer");

   // busy is a single refetch cycle right after an accept
   a_busy_cause: assert property (@(posedge clock) disable iff (reset)
      busy |-> ($past(start) && !$past(busy)))
      else $error("busy without preceding accept");

   a_busy_short: assert property (@(posedge clock) disable iff (reset)
      busy |=> !busy)
      else $error("busy held longer than one cycle");

   // non-read commands return zero
   a_zero_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && $past(req_cmd) != CMD_READ_LO && $past(req_cmd) != CMD_READ_HI)
      |-> (rsp_read_byte == '0))
      else $error("nonzero byte for non-read command");

endmodule

bind vram_access_port vap_checker u_vap_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_cmd       (req_cmd),
   .rsp_strobe    (rsp_strobe),
   .rsp_read_byte (rsp_read_byte)
);
